### rtl/swaabb_pkg.sv
// package: widths, codes, types and the per-axis set-up function of the swept box test
`timescale 1ns / 1ps
package swaabb_pkg;

    localparam int CW     = 16;
    localparam int TF     = 15;
    localparam int QW     = TF + 1;
    localparam int SPS    = 4;
    localparam int NST    = (QW + SPS - 1) / SPS;
    localparam int PW     = CW + QW;
    localparam int IN_W   = ((10 * CW + 7) / 8) * 8;
    localparam int OUT_RAW = 2 + 2 * CW + 4;
    localparam int OUT_W  = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [QW-1:0] T_ONE = QW'(1) << TF;

    localparam logic [1:0] NRM_NONE = 2'b00;
    localparam logic [1:0] NRM_POS  = 2'b01;
    localparam logic [1:0] NRM_NEG  = 2'b11;

    typedef struct packed {
        logic          fail;
        logic          need_exit;
        logic          need_entry;
        logic          vpos;
        logic [CW-1:0] g_exit;
        logic [CW-1:0] g_entry;
        logic [CW-1:0] spd;
    } t_axis;

    typedef struct packed {
        logic  ovl;
        t_axis ax;
        t_axis ay;
    } t_side;

    function automatic logic [CW-1:0] sub_lo(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b);
        logic [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        return d[CW-1:0];
    endfunction

    function automatic t_axis axis_prep(logic signed [CW-1:0] mn,
                                        logic signed [CW-1:0] mx,
                                        logic signed [CW-1:0] tmn,
                                        logic signed [CW-1:0] tmx,
                                        logic signed [CW-1:0] v);
        t_axis r;
        logic [CW:0] nv;
        nv = {CW+1{1'b0}} - {v[CW-1], v};
        r = '0;
        r.vpos = 1'b0;
        if (v > 0) begin
            r.vpos       = 1'b1;
            r.spd        = v;
            r.fail       = tmx < mn;
            r.need_exit  = tmx > mn;
            r.g_exit     = sub_lo(tmx, mn);
            r.need_entry = mx < tmn;
            r.g_entry    = sub_lo(tmn, mx);
        end else if (v < 0) begin
            r.spd        = nv[CW-1:0];
            r.fail       = tmn > mx;
            r.need_exit  = mx > tmn;
            r.g_exit     = sub_lo(mx, tmn);
            r.need_entry = tmx < mn;
            r.g_entry    = sub_lo(mn, tmx);
        end else begin
            r.spd  = '0;
            r.fail = (mx < tmn) || (mn > tmx);
        end
        return r;
    endfunction

endpackage

### rtl/swaabb_div.sv
// pipelined restoring divider: (gap << TF) / div, saturated once the quotient reaches two
`timescale 1ns / 1ps
module swaabb_div (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [swaabb_pkg::CW-1:0] i_gap,
    input  logic [swaabb_pkg::CW-1:0] i_div,
    output logic [swaabb_pkg::QW-1:0] o_q
);
    import swaabb_pkg::*;

    logic [CW:0]   r_rem [NST];
    logic [QW-1:0] r_q   [NST];
    logic [CW-1:0] r_d   [NST];
    logic          r_sat [NST];

    logic [CW:0]   c_rem [NST];
    logic [QW-1:0] c_q   [NST];
    logic [CW-1:0] c_d   [NST];
    logic          c_sat [NST];

    logic [CW-1:0] w_div;
    assign w_div = (i_div == '0) ? CW'(1) : i_div;

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_st
            if (s == 0) begin : g_first
                assign c_rem[s] = {1'b0, i_gap};
                assign c_q[s]   = '0;
                assign c_d[s]   = w_div;
                assign c_sat[s] = {1'b0, i_gap} >= {w_div, 1'b0};
            end else begin : g_next
                assign c_rem[s] = r_rem[s-1];
                assign c_q[s]   = r_q[s-1];
                assign c_d[s]   = r_d[s-1];
                assign c_sat[s] = r_sat[s-1];
            end

            logic [CW:0]   n_rem;
            logic [QW-1:0] n_q;
            always_comb begin
                n_rem = c_rem[s];
                n_q   = c_q[s];
                for (int k = 0; k < SPS; k++) begin
                    if (s * SPS + k < QW) begin
                        if (s * SPS + k != 0) begin
                            n_rem = {n_rem[CW-1:0], 1'b0};
                        end
                        if (n_rem >= {1'b0, c_d[s]}) begin
                            n_rem = n_rem - {1'b0, c_d[s]};
                            n_q   = {n_q[QW-2:0], 1'b1};
                        end else begin
                            n_q   = {n_q[QW-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_q[s]   <= n_q;
                    r_d[s]   <= c_d[s];
                    r_sat[s] <= c_sat[s];
                end
            end
        end
    endgenerate

    assign o_q = r_sat[NST-1] ? {QW{1'b1}} : r_q[NST-1];

endmodule

### rtl/swept_aabb_collision.sv
// top level: swept box collision test, pipelined at one query per cycle while not stalled
//
// slave stream carries one query per transfer: mover box, still box and the
// mover's displacement for one frame, all q12.4. master stream returns one
// result per query in the same order: hit, already-overlapping flag, the
// displacement scaled by the entry time and the unit hit normal.
// eight register stages: one set-up stage, four divider stages (four quotient
// bits each, four dividers in parallel), a time-combine stage, a multiplier
// stage and the output register; the input transfer edge itself loads the
// set-up stage.
// a new query is taken every cycle while the master side keeps taking
// results; throughput is set by the divider pipeline, one query per cycle.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and tready drops; nothing is lost or repeated.
// reset (synchronous, active low) clears all valid bits; payload is not
// cleared. there is no configuration.
`timescale 1ns / 1ps
module swept_aabb_collision (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // mover_min_x, mover_min_y, mover_max_x, mover_max_y, target_min_x,
    // target_min_y, target_max_x, target_max_y, vel_x, vel_y
    input  logic [swaabb_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // hit, already_overlapping, out_vel_x, out_vel_y, normal_x, normal_y
    output logic [swaabb_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import swaabb_pkg::*;

    logic en;
    logic r_ov;
    assign en = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic signed [CW-1:0] mnx, mny, mxx, mxy, tnx, tny, txx, txy, vx, vy;
    assign mnx = i_s_axis_tdata[0*CW +: CW];
    assign mny = i_s_axis_tdata[1*CW +: CW];
    assign mxx = i_s_axis_tdata[2*CW +: CW];
    assign mxy = i_s_axis_tdata[3*CW +: CW];
    assign tnx = i_s_axis_tdata[4*CW +: CW];
    assign tny = i_s_axis_tdata[5*CW +: CW];
    assign txx = i_s_axis_tdata[6*CW +: CW];
    assign txy = i_s_axis_tdata[7*CW +: CW];
    assign vx  = i_s_axis_tdata[8*CW +: CW];
    assign vy  = i_s_axis_tdata[9*CW +: CW];

    t_side n_sd0;
    always_comb begin
        n_sd0.ovl = !(mxx < tnx || mxy < tny || mnx > txx || mny > txy);
        n_sd0.ax  = axis_prep(mnx, mxx, tnx, txx, vx);
        n_sd0.ay  = axis_prep(mny, mxy, tny, txy, vy);
    end

    // side band travels alongside the dividers
    t_side r_sd [NST+1];
    logic  r_v  [NST+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= n_sd0;
            for (int s = 0; s < NST; s++) begin
                r_sd[s+1] <= r_sd[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_s_axis_tvalid;
            for (int s = 0; s < NST; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    logic [QW-1:0] q_xo, q_xe, q_yo, q_ye;

    swaabb_div u_div_xo (.i_clk(i_clk), .i_en(en), .i_gap(r_sd[0].ax.g_exit),
                         .i_div(r_sd[0].ax.spd), .o_q(q_xo));
    swaabb_div u_div_xe (.i_clk(i_clk), .i_en(en), .i_gap(r_sd[0].ax.g_entry),
                         .i_div(r_sd[0].ax.spd), .o_q(q_xe));
    swaabb_div u_div_yo (.i_clk(i_clk), .i_en(en), .i_gap(r_sd[0].ay.g_exit),
                         .i_div(r_sd[0].ay.spd), .o_q(q_yo));
    swaabb_div u_div_ye (.i_clk(i_clk), .i_en(en), .i_gap(r_sd[0].ay.g_entry),
                         .i_div(r_sd[0].ay.spd), .o_q(q_ye));

    // combine times
    t_side         sd;
    logic [QW-1:0] ex, ey, hit_t, out_t;
    logic          hit_ok;
    logic          n5_hit, n5_ovl;
    logic [QW-1:0] n5_t;
    logic [1:0]    n5_nx, n5_ny;

    assign sd = r_sd[NST];

    always_comb begin
        ex    = sd.ax.need_entry ? q_xe : '0;
        ey    = sd.ay.need_entry ? q_ye : '0;
        hit_t = (ex > ey) ? ex : ey;
        out_t = T_ONE;
        if (sd.ax.need_exit && q_xo < out_t) begin
            out_t = q_xo;
        end
        if (sd.ay.need_exit && q_yo < out_t) begin
            out_t = q_yo;
        end
        hit_ok = !sd.ovl && !sd.ax.fail && !sd.ay.fail && (hit_t <= out_t);
        n5_ovl = sd.ovl;
        n5_hit = sd.ovl || hit_ok;
        n5_t   = hit_ok ? hit_t : '0;
        n5_nx  = NRM_NONE;
        n5_ny  = NRM_NONE;
        if (hit_ok) begin
            if (ex > ey) begin
                n5_nx = sd.ax.vpos ? NRM_NEG : NRM_POS;
            end else begin
                n5_ny = sd.ay.vpos ? NRM_NEG : NRM_POS;
            end
        end
    end

    logic          r5_v, r5_hit, r5_ovl, r5_negx, r5_negy;
    logic [QW-1:0] r5_t;
    logic [CW-1:0] r5_spdx, r5_spdy;
    logic [1:0]    r5_nx, r5_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hit  <= n5_hit;
            r5_ovl  <= n5_ovl;
            r5_t    <= n5_t;
            r5_spdx <= sd.ax.spd;
            r5_spdy <= sd.ay.spd;
            r5_negx <= !sd.ax.vpos;
            r5_negy <= !sd.ay.vpos;
            r5_nx   <= n5_nx;
            r5_ny   <= n5_ny;
        end
    end

    logic          r6_v, r6_hit, r6_ovl, r6_negx, r6_negy;
    logic [PW-1:0] r6_px, r6_py;
    logic [1:0]    r6_nx, r6_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_px   <= PW'(r5_spdx) * PW'(r5_t);
            r6_py   <= PW'(r5_spdy) * PW'(r5_t);
            r6_hit  <= r5_hit;
            r6_ovl  <= r5_ovl;
            r6_negx <= r5_negx;
            r6_negy <= r5_negy;
            r6_nx   <= r5_nx;
            r6_ny   <= r5_ny;
        end
    end

    logic [CW-1:0] mag_x, mag_y, n_vx, n_vy;
    assign mag_x = r6_px[TF +: CW];
    assign mag_y = r6_py[TF +: CW];
    assign n_vx  = r6_negx ? (CW'(0) - mag_x) : mag_x;
    assign n_vy  = r6_negy ? (CW'(0) - mag_y) : mag_y;

    logic [OUT_W-1:0] r_od;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od <= OUT_W'({r6_ny, r6_nx, n_vy, n_vx, r6_ovl, r6_hit});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r5_v <= r_v[NST];
            r6_v <= r5_v;
            r_ov <= r6_v;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

`ifndef ASSERT_OFF
    a_ovl_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od[1]) |-> (r_od[0] && r_od[2 +: 2*CW + 4] == '0))
        else $error("overlap result carries non-zero fields");

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_od[0]) |-> (r_od[OUT_RAW-1:1] == '0))
        else $error("miss result carries non-zero fields");

    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od[2+2*CW +: 2] == NRM_NONE || r_od[4+2*CW +: 2] == NRM_NONE))
        else $error("normal on both axes");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_axis_tready) |=> (r_ov && $stable(r_od)))
        else $error("stalled result changed");
`endif

endmodule
